### rtl/i2a_pkg.sv
// Shared types, constants and helper functions for the integer-to-ASCII converter.
package i2a_pkg;

    // Format kinds carried on the input transfer
    localparam logic [1:0] KIND_SIGNED = 2'd0;
    localparam logic [1:0] KIND_HEX    = 2'd1;

    // ASCII codes used by the character generator
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A     = 8'h61;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;

    // Input transfer payload
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
    } in_item_t;

    // Result transfer payload
    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } out_item_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIGN,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic conv_step;
        logic skip_step;
        logic push_sign;
        logic push_digit;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic neg;
        logic hex;
        logic conv_last;
        logic lead_zero;
        logic last_digit;
        logic out_free;
    } dp_stat_t;

    // Map a digit value 0..15 to its lowercase ASCII character
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CHAR_ZERO + {4'b0000, d};
        end else begin
            c = CHAR_A + {4'b0000, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

### rtl/i2a_dpath.sv
// Datapath: magnitude and digit registers, bit-serial BCD conversion, output register.
module i2a_dpath #(
    parameter int VALUE_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  i2a_pkg::in_item_t   s_data,
    input  i2a_pkg::dp_cmd_t    cmd,
    output i2a_pkg::dp_stat_t   stat,
    input  logic                m_ready,
    output logic                m_valid,
    output i2a_pkg::out_item_t  m_data
);

    localparam int NDIG = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int HDIG = (VALUE_BITS + 3) / 4;
    localparam int DW   = NDIG * 4;
    localparam int HW   = HDIG * 4;
    localparam int CW   = $clog2(VALUE_BITS);
    localparam int RW   = $clog2(NDIG + 1);

    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [DW-1:0]         dig_reg, dig_next;
    logic [CW-1:0]         bit_cnt_reg, bit_cnt_next;
    logic [RW-1:0]         rem_reg, rem_next;
    logic                  neg_reg, neg_next;
    logic                  hex_reg, hex_next;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            out_char_reg, out_char_next;
    logic                  out_last_reg, out_last_next;

    logic [VALUE_BITS-1:0] in_val;
    logic [VALUE_BITS-1:0] in_mag;
    logic                  in_neg;
    logic [HW-1:0]         hex_pad;
    logic [DW-1:0]         dig_adj;
    logic [3:0]            top_digit;

    // Decode the incoming value: sign, magnitude, hex nibbles zero-padded to whole nibbles
    always_comb begin
        in_val  = s_data.value[VALUE_BITS-1:0];
        in_neg  = (s_data.kind == i2a_pkg::KIND_SIGNED) && in_val[VALUE_BITS-1];
        in_mag  = in_neg ? ((~in_val) + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : in_val;
        hex_pad = HW'(in_val);
    end

    // Add 3 to every BCD digit of 5 or more before the next shift
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            dig_adj[i*4 +: 4] = (dig_reg[i*4 +: 4] >= 4'd5) ?
                                (dig_reg[i*4 +: 4] + 4'd3) : dig_reg[i*4 +: 4];
        end
        top_digit = dig_reg[DW-1 -: 4];
    end

    // Next values of the working registers
    always_comb begin
        mag_next     = mag_reg;
        dig_next     = dig_reg;
        bit_cnt_next = bit_cnt_reg;
        rem_next     = rem_reg;
        neg_next     = neg_reg;
        hex_next     = hex_reg;
        if (cmd.load) begin
            mag_next     = in_mag;
            neg_next     = in_neg;
            hex_next     = (s_data.kind == i2a_pkg::KIND_HEX);
            bit_cnt_next = '0;
            if (s_data.kind == i2a_pkg::KIND_HEX) begin
                dig_next = DW'(hex_pad) << (DW - HW);
                rem_next = RW'(HDIG);
            end else begin
                dig_next = '0;
                rem_next = RW'(NDIG);
            end
        end else if (cmd.conv_step) begin
            dig_next     = {dig_adj[DW-2:0], mag_reg[VALUE_BITS-1]};
            mag_next     = {mag_reg[VALUE_BITS-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + 1'b1;
        end else if (cmd.skip_step || cmd.push_digit) begin
            dig_next = {dig_reg[DW-5:0], 4'b0000};
            rem_next = rem_reg - 1'b1;
        end
    end

    // Output register: drop on transfer, fill on push
    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (cmd.push_sign) begin
            out_valid_next = 1'b1;
            out_char_next  = i2a_pkg::CHAR_MINUS;
            out_last_next  = 1'b0;
        end else if (cmd.push_digit) begin
            out_valid_next = 1'b1;
            out_char_next  = i2a_pkg::digit_char(top_digit);
            out_last_next  = (rem_reg == RW'(1));
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload state
    always_ff @(posedge aclk) begin
        mag_reg      <= mag_next;
        dig_reg      <= dig_next;
        bit_cnt_reg  <= bit_cnt_next;
        rem_reg      <= rem_next;
        neg_reg      <= neg_next;
        hex_reg      <= hex_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    // Status back to the controller
    always_comb begin
        stat.neg        = neg_reg;
        stat.hex        = hex_reg;
        stat.conv_last  = (bit_cnt_reg == CW'(VALUE_BITS - 1));
        stat.lead_zero  = (top_digit == 4'd0) && (rem_reg > RW'(1));
        stat.last_digit = (rem_reg == RW'(1));
        stat.out_free   = !out_valid_reg || m_ready;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = '{character: out_char_reg, last: out_last_reg};

endmodule

### rtl/i2a_ctrl.sv
// Controller: sequences load, sign, conversion, leading-zero skip and character emission.
module i2a_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  i2a_pkg::dp_stat_t  stat,
    output i2a_pkg::dp_cmd_t   cmd
);

    i2a_pkg::state_t state_reg, state_next;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            i2a_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = i2a_pkg::ST_SIGN;
                end
            end
            i2a_pkg::ST_SIGN: begin
                if (!stat.neg) begin
                    state_next = stat.hex ? i2a_pkg::ST_SKIP : i2a_pkg::ST_CONV;
                end else if (stat.out_free) begin
                    state_next = i2a_pkg::ST_CONV;
                end
            end
            i2a_pkg::ST_CONV: begin
                if (stat.conv_last) begin
                    state_next = i2a_pkg::ST_SKIP;
                end
            end
            i2a_pkg::ST_SKIP: begin
                if (!stat.lead_zero) begin
                    state_next = i2a_pkg::ST_EMIT;
                end
            end
            i2a_pkg::ST_EMIT: begin
                if (stat.out_free && stat.last_digit) begin
                    state_next = i2a_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = i2a_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        s_ready        = 1'b0;
        cmd            = '0;
        case (state_reg)
            i2a_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            i2a_pkg::ST_SIGN: begin
                cmd.push_sign = stat.neg && stat.out_free;
            end
            i2a_pkg::ST_CONV: begin
                cmd.conv_step = 1'b1;
            end
            i2a_pkg::ST_SKIP: begin
                cmd.skip_step = stat.lead_zero;
            end
            i2a_pkg::ST_EMIT: begin
                cmd.push_digit = stat.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= i2a_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/integer_to_ascii_dec_hex_top.sv
// Top level of the integer-to-ASCII converter: controller, datapath and checks.
// Converts one value at a time to ASCII text, one character per result transfer, most
// significant digit first, with last set on the final character. Kind 0 is signed decimal
// (a leading '-' for negative values), kind 1 is lowercase hex of the raw bit pattern, any
// other kind is unsigned decimal; zero prints as a single '0'. Only the low VALUE_BITS bits
// of value are used (VALUE_BITS from 8 to 32). A decimal item first runs the shift-and-add-3
// BCD loop, which consumes one input bit per cycle, then skips leading zeros and emits its
// digits; a hex item skips that loop. A minus sign does not lengthen an item, but the block
// waits whenever it has a character to push while the previous one is not yet taken.
// A new item is accepted once the last character of the previous one sits in the output
// register.
module integer_to_ascii_dec_hex_top #(
    parameter int VALUE_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  i2a_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output i2a_pkg::out_item_t  m_data
);

    i2a_pkg::dp_cmd_t  cmd;
    i2a_pkg::dp_stat_t stat;

    // Sequence the work of one item
    i2a_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Hold the value, convert it and present characters
    i2a_dpath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

    // The block is busy right after taking an input transfer
    a_busy_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while previous item still in progress");

    // A minus sign is never the final character
    a_sign_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.character == i2a_pkg::CHAR_MINUS)) |-> !m_data.last)
        else $error("minus sign marked as last character");

    // While a non-final character waits, the item is not finished
    a_no_accept_mid_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.last) |-> !s_ready)
        else $error("input ready before the current item is fully emitted");

endmodule

### tb/sv/integer_to_ascii_dec_hex_checker.sv
// Checker for the integer-to-ASCII converter: predicts the text of each value and compares it.
module integer_to_ascii_dec_hex_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  i2a_pkg::in_item_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  i2a_pkg::out_item_t m_data,
    output int                 fail_count,
    output int                 chars_pending
);

    // Characters still owed by the block, oldest first
    i2a_pkg::out_item_t expected_chars[$];
    i2a_pkg::out_item_t want;

    // Append the text of one value: optional sign, then digits, most significant first
    task automatic push_text(input i2a_pkg::in_item_t item);
        logic [31:0]        magnitude;
        logic [4:0]         radix;
        logic [3:0]         digits[$];
        logic               negative;
        i2a_pkg::out_item_t ch;
        negative  = (item.kind == i2a_pkg::KIND_SIGNED) && item.value[31];
        magnitude = negative ? -item.value : item.value;
        radix     = (item.kind == i2a_pkg::KIND_HEX) ? 5'd16 : 5'd10;
        // Peel digits off the low end; zero still yields one digit
        do begin
            digits.push_back(4'(magnitude % radix));
            magnitude = magnitude / radix;
        end while (magnitude != 0);
        if (negative) begin
            ch.character = i2a_pkg::CHAR_MINUS;
            ch.last      = 1'b0;
            expected_chars.push_back(ch);
        end
        for (int i = digits.size() - 1; i >= 0; i--) begin
            if (digits[i] < 4'd10) begin
                ch.character = i2a_pkg::CHAR_ZERO + 8'(digits[i]);
            end else begin
                ch.character = i2a_pkg::CHAR_A + 8'(digits[i]) - 8'd10;
            end
            ch.last = (i == 0);
            expected_chars.push_back(ch);
        end
    endtask

    // Compare each result transfer, then predict from each input transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_chars.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_chars.size() == 0) begin
                    $error("unexpected result: character %h last %b",
                           m_data.character, m_data.last);
                    fail_count++;
                end else begin
                    want = expected_chars.pop_front();
                    if (m_data.character !== want.character) begin
                        $error("character: expected %h, actual %h",
                               want.character, m_data.character);
                        fail_count++;
                    end
                    if (m_data.last !== want.last) begin
                        $error("last: expected %b, actual %b", want.last, m_data.last);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                push_text(s_data);
            end
        end
        chars_pending = expected_chars.size();
    end

endmodule

### tb/sv/integer_to_ascii_dec_hex_top_test.sv
// Testbench top for the integer-to-ASCII converter: clock, reset, stimulus and verdict.
module integer_to_ascii_dec_hex_top_test;

    // Kinds that print unsigned decimal
    localparam logic [1:0] KIND_UNSIGNED = 2'd2;
    localparam logic [1:0] KIND_SPARE    = 2'd3;

    localparam int RANDOM_ITEMS    = 250;
    localparam int IDLE_PERCENT    = 29;
    localparam int HOLD_OFF_START  = 1500;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 60;
    localparam int RUN_LIMIT       = 200000 * 8;

    // Zeros, all ones, sign boundaries, digit rollovers and one of every kind
    localparam i2a_pkg::in_item_t DIRECTED [0:21] = '{
        '{i2a_pkg::KIND_SIGNED, 32'h0000_0000},
        '{i2a_pkg::KIND_HEX,    32'h0000_0000},
        '{KIND_UNSIGNED,        32'h0000_0000},
        '{KIND_SPARE,           32'h0000_0000},
        '{i2a_pkg::KIND_SIGNED, 32'hFFFF_FFFF},
        '{i2a_pkg::KIND_HEX,    32'hFFFF_FFFF},
        '{KIND_UNSIGNED,        32'hFFFF_FFFF},
        '{KIND_SPARE,           32'hFFFF_FFFF},
        '{i2a_pkg::KIND_SIGNED, 32'h8000_0000},
        '{i2a_pkg::KIND_HEX,    32'h8000_0000},
        '{KIND_UNSIGNED,        32'h8000_0000},
        '{i2a_pkg::KIND_SIGNED, 32'h7FFF_FFFF},
        '{i2a_pkg::KIND_HEX,    32'h7FFF_FFFF},
        '{i2a_pkg::KIND_SIGNED, 32'h0000_0001},
        '{i2a_pkg::KIND_SIGNED, 32'h0000_0009},
        '{i2a_pkg::KIND_SIGNED, 32'h0000_000A},
        '{i2a_pkg::KIND_HEX,    32'h0000_000F},
        '{i2a_pkg::KIND_HEX,    32'h0000_0010},
        '{KIND_UNSIGNED,        32'h3B9A_CA00},
        '{KIND_UNSIGNED,        32'h3B9A_C9FF},
        '{i2a_pkg::KIND_SIGNED, 32'hFFFF_FFF6},
        '{i2a_pkg::KIND_HEX,    32'hDEAD_BEEF}
    };

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    i2a_pkg::in_item_t  s_data  = '0;
    logic               m_ready = 1'b0;
    logic               s_ready;
    logic               m_valid;
    i2a_pkg::out_item_t m_data;
    int                 fail_count;
    int                 chars_pending;
    bit                 steady = 1'b0;

    always #4 aclk = ~aclk;

    integer_to_ascii_dec_hex_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    integer_to_ascii_dec_hex_checker text_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (fail_count),
        .chars_pending (chars_pending)
    );

    // Mix short numbers, negatives, sign boundaries and full-width patterns
    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(5))
            0: v = $urandom_range(9);
            1: v = $urandom_range(99999);
            2: v = -$urandom_range(99999);
            3: v = $urandom_range(1) ? 32'h8000_0000 + $urandom_range(15)
                                     : 32'h7FFF_FFFF - $urandom_range(15);
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // Offer one item after a random gap (none in the steady stretch) and hold it until the transfer
    task automatic send_item(input i2a_pkg::in_item_t item);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = item;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Stimulus and verdict
    initial begin
        i2a_pkg::in_item_t item;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        foreach (DIRECTED[i]) begin
            send_item(DIRECTED[i]);
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Run a stretch with no gaps on either side
            steady     = (n >= 100 && n < 150);
            item.kind  = 2'($urandom_range(3));
            item.value = pick_value();
            send_item(item);
        end
        s_valid = 1'b0;
        steady  = 1'b0;
        while (chars_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off so the block backs up
    initial begin
        int cycle;
        cycle = 0;
        forever begin
            @(negedge aclk);
            cycle++;
            if (cycle > HOLD_OFF_START && cycle <= HOLD_OFF_START + HOLD_OFF_CYCLES) begin
                m_ready = 1'b0;
            end else begin
                m_ready = steady || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // Stop a hung run
    initial begin
        #(RUN_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

### integer_to_ascii_dec_hex_top.f
rtl/i2a_pkg.sv
rtl/i2a_dpath.sv
rtl/i2a_ctrl.sv
rtl/integer_to_ascii_dec_hex_top.sv
tb/sv/integer_to_ascii_dec_hex_checker.sv
tb/sv/integer_to_ascii_dec_hex_top_test.sv
